// ===== rtl/capability_handle_table_top_assert.svh =====
// assertion macros for the capability handle table
// used by capability_handle_table_top; expects clk and rst_n in scope
`ifndef CAPABILITY_HANDLE_TABLE_TOP_ASSERT_SVH
`define CAPABILITY_HANDLE_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CHT_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("cht assertion failed");
`define CHT_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cht assertion failed");
`else
`define CHT_ASSERT_IMP(name, pre, post)
`define CHT_ASSERT_NXT(name, pre, post)
`endif

`endif

// ===== rtl/cht_pkg.sv =====
// shared types, widths and codes of the capability handle table
// no dependencies
package cht_pkg;

  localparam int HANDLES     = 64;
  localparam int OBJECT_BITS = 32;
  localparam int RIGHTS_BITS = 8;

  localparam int CMD_W      = 2;
  localparam int HANDLE_W   = 6;
  localparam int KIND_W     = 3;
  localparam int OBJECT_W   = 32;
  localparam int RIGHTS_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int HIDX_W = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam int OBJ_W  = (OBJECT_BITS < OBJECT_W) ? OBJECT_BITS : OBJECT_W;
  localparam int RGT_W  = (RIGHTS_BITS < RIGHTS_W) ? RIGHTS_BITS : RIGHTS_W;

  localparam int FREE_GRP   = 8;
  localparam int FREE_NGRP  = (HANDLES + FREE_GRP - 1) / FREE_GRP;
  localparam int FREE_BIT_W = $clog2(FREE_GRP);

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER  = 2'd0,
    CMD_CLOSE     = 2'd1,
    CMD_DUPLICATE = 2'd2,
    CMD_LOOKUP    = 2'd3
  } cmd_t;

  localparam logic [KIND_W-1:0] KIND_NONE    = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_CHANNEL = KIND_W'(3);
  localparam logic [KIND_W-1:0] KIND_MAX     = KIND_W'(5);

  localparam logic [CFG_IDX_W-1:0] CFG_DELEGATE_MASK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_READ_MASK     = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] DELEGATE_RESET = CFG_DATA_W'(8);
  localparam logic [CFG_DATA_W-1:0] READ_RESET     = CFG_DATA_W'(1);

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OBJ_W-1:0]  object;
    logic [RGT_W-1:0]  rights;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic              set;
    logic [HIDX_W-1:0] idx;
  } valid_upd_t;

  typedef struct packed {
    logic              found;
    logic [HIDX_W-1:0] free_idx;
    logic              qvalid;
  } alloc_stat_t;

endpackage

// ===== rtl/cht_in_if.sv =====
// command channel of the capability handle table
// depends on cht_pkg
interface cht_in_if import cht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [HANDLE_W-1:0] handle;
  logic [KIND_W-1:0]   kind;
  logic [OBJECT_W-1:0] object;
  logic [RIGHTS_W-1:0] rights;

  modport source (output valid, cmd, handle, kind, object, rights, input ready);
  modport sink (input valid, cmd, handle, kind, object, rights, output ready);
endinterface

// ===== rtl/cht_out_if.sv =====
// result channel of the capability handle table
// depends on cht_pkg
interface cht_out_if import cht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                ok;
  logic [HANDLE_W-1:0] handle_out;
  logic [KIND_W-1:0]   kind_out;
  logic [OBJECT_W-1:0] object_out;
  logic [RIGHTS_W-1:0] rights_out;

  modport source (output valid, ok, handle_out, kind_out, object_out, rights_out,
                  input ready);
  modport sink (input valid, ok, handle_out, kind_out, object_out, rights_out,
                output ready);
endinterface

// ===== rtl/cht_cfg_if.sv =====
// register write channel of the capability handle table
// depends on cht_pkg
interface cht_cfg_if import cht_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/capability_handle_table_top.sv =====
// Capability handle table: 64 handles of kind, object id and rights, handle 0 reserved.
// For each command the accepting edge reads the entry memory and registers the first
// stage of the free-handle search; in the execute state, once the result register is
// free, the block decides and writes back. New commands are taken only in the idle state,
// after the write-back; a full result register holds the block until it drains.
// Entry validity lives in flip-flops cleared at reset, so no clearing pass is needed.
// depends on cht_pkg, the channel interfaces, cht_mem, cht_alloc and the assertion header
`include "capability_handle_table_top_assert.svh"

module capability_handle_table_top import cht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cht_in_if.sink    in_if,
  cht_out_if.source out_if,
  cht_cfg_if.sink   cfg_if
);

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r;
  logic [HANDLE_W-1:0]   handle_r;
  logic [KIND_W-1:0]     kind_r;
  logic [OBJ_W-1:0]      obj_r;
  logic [RGT_W-1:0]      rights_r;
  logic [CFG_DATA_W-1:0] delegate_r;
  logic [CFG_DATA_W-1:0] read_r;

  logic                  out_valid_r, out_valid_nxt;
  logic                  ok_r, ok_nxt;
  logic [HANDLE_W-1:0]   hout_r, hout_nxt;
  logic [KIND_W-1:0]     kout_r, kout_nxt;
  logic [OBJECT_W-1:0]   oout_r, oout_nxt;
  logic [RIGHTS_W-1:0]   rout_r, rout_nxt;

  logic                  in_fire;
  logic                  out_free;
  logic                  go;
  logic                  handle_ok;
  logic                  hvalid;
  logic [HIDX_W-1:0]     hidx;
  entry_t                rd_entry;
  entry_t                wr_entry;
  logic                  mem_we;
  logic [HIDX_W-1:0]     mem_waddr;
  valid_upd_t            upd;
  alloc_stat_t           stat;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign go       = (state_r == ST_EXEC) && out_free;

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;

  assign handle_ok = (handle_r != '0) && (int'(handle_r) < HANDLES);
  assign hidx      = HIDX_W'(handle_r);
  assign hvalid    = handle_ok && stat.qvalid;

  cht_mem #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (HANDLES)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (wr_entry),
    .re      (in_fire),
    .raddr   (HIDX_W'(in_if.handle)),
    .rdata_r (rd_entry)
  );

  cht_alloc u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .qidx  (hidx),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      delegate_r  <= DELEGATE_RESET;
      read_r      <= READ_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_DELEGATE_MASK) begin
          delegate_r <= cfg_if.data;
        end else if (cfg_if.index == CFG_READ_MASK) begin
          read_r <= cfg_if.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= cmd_t'(in_if.cmd);
      handle_r <= in_if.handle;
      kind_r   <= in_if.kind;
      obj_r    <= OBJ_W'(in_if.object);
      rights_r <= RGT_W'(in_if.rights);
    end
    if (go) begin
      ok_r   <= ok_nxt;
      hout_r <= hout_nxt;
      kout_r <= kout_nxt;
      oout_r <= oout_nxt;
      rout_r <= rout_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    ok_nxt        = 1'b0;
    hout_nxt      = '0;
    kout_nxt      = '0;
    oout_nxt      = '0;
    rout_nxt      = '0;
    mem_we        = 1'b0;
    mem_waddr     = stat.free_idx;
    wr_entry      = '{kind: kind_r, object: obj_r, rights: rights_r};
    upd           = '{en: 1'b0, set: 1'b1, idx: stat.free_idx};

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          case (cmd_r)
            CMD_REGISTER: begin
              if (kind_r != KIND_NONE && kind_r <= KIND_MAX && obj_r != '0 &&
                  stat.found) begin
                ok_nxt   = 1'b1;
                hout_nxt = HANDLE_W'(stat.free_idx);
                mem_we   = 1'b1;
                upd.en   = 1'b1;
              end
            end
            CMD_CLOSE: begin
              if (hvalid) begin
                ok_nxt  = 1'b1;
                upd     = '{en: 1'b1, set: 1'b0, idx: hidx};
              end
            end
            CMD_DUPLICATE: begin
              if (hvalid && (rights_r & ~rd_entry.rights) == '0 &&
                  (RIGHTS_W'(rd_entry.rights) & delegate_r) != '0 && stat.found) begin
                ok_nxt   = 1'b1;
                hout_nxt = HANDLE_W'(stat.free_idx);
                wr_entry = '{kind: rd_entry.kind, object: rd_entry.object,
                             rights: rights_r};
                mem_we   = 1'b1;
                upd.en   = 1'b1;
              end
            end
            CMD_LOOKUP: begin
              if (hvalid && (kind_r == KIND_NONE || kind_r == rd_entry.kind) &&
                  !(rd_entry.kind == KIND_CHANNEL &&
                    (RIGHTS_W'(rd_entry.rights) & read_r) == '0)) begin
                ok_nxt   = 1'b1;
                kout_nxt = rd_entry.kind;
                oout_nxt = OBJECT_W'(rd_entry.object);
                rout_nxt = RIGHTS_W'(rd_entry.rights);
              end
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.ok         = ok_r;
  assign out_if.handle_out = hout_r;
  assign out_if.kind_out   = kout_r;
  assign out_if.object_out = oout_r;
  assign out_if.rights_out = rout_r;

  `CHT_ASSERT_NXT(a_accept_exec, in_fire, state_r == ST_EXEC)
  `CHT_ASSERT_IMP(a_alloc_found, go && upd.en && upd.set, stat.found)
  `CHT_ASSERT_IMP(a_fail_zero, out_if.valid && !out_if.ok, out_if.handle_out == '0 && out_if.kind_out == '0 && out_if.object_out == '0 && out_if.rights_out == '0)

endmodule

// ===== rtl/cht_mem.sv =====
// generic single-port-write ram with registered read
// no dependencies
module cht_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cht_alloc.sv =====
// entry valid bits and two-stage lowest-free-handle search
// depends on cht_pkg
module cht_alloc import cht_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  valid_upd_t        upd,
  input  logic [HIDX_W-1:0] qidx,
  output alloc_stat_t       stat
);

  logic [HANDLES-1:0]              valid_r;
  logic [HANDLES-1:0]              valid_nxt;
  logic [FREE_NGRP*FREE_GRP-1:0]   free_pad;
  logic [FREE_NGRP-1:0]            grp_any_r;
  logic [FREE_NGRP-1:0]            grp_any_nxt;
  logic [FREE_BIT_W-1:0]           grp_bit_r [FREE_NGRP];
  logic [FREE_BIT_W-1:0]           grp_bit_nxt [FREE_NGRP];

  always_comb begin
    valid_nxt = valid_r;
    if (upd.en) begin
      valid_nxt[upd.idx] = upd.set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // handle 0 and padding never count as free
  always_comb begin
    free_pad = '0;
    for (int i = 1; i < HANDLES; i++) begin
      free_pad[i] = !valid_r[i];
    end
  end

  always_comb begin
    for (int g = 0; g < FREE_NGRP; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_bit_nxt[g] = '0;
      for (int b = FREE_GRP - 1; b >= 0; b--) begin
        if (free_pad[g*FREE_GRP + b]) begin
          grp_any_nxt[g] = 1'b1;
          grp_bit_nxt[g] = FREE_BIT_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    grp_bit_r <= grp_bit_nxt;
  end

  always_comb begin
    stat.found    = 1'b0;
    stat.free_idx = '0;
    for (int g = FREE_NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        stat.found    = 1'b1;
        stat.free_idx = HIDX_W'(g * FREE_GRP + int'(grp_bit_r[g]));
      end
    end
    stat.qvalid = valid_r[qidx];
  end

endmodule
